// File: design/boce_pkg.sv
// Shared constants, operation codes and types for the bit offset copy engine.
package boce_pkg;

  localparam int MEM_BYTES = 256;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int BIT_W     = ADDR_W + 3;
  localparam int CNT_W     = BIT_W + 1;
  localparam int SUM_W     = CNT_W + 1;

  localparam logic [SUM_W-1:0] BIT_LIMIT = SUM_W'(MEM_BYTES * 8);

  typedef logic [1:0]        boce_op_t;
  typedef logic [ADDR_W-1:0] boce_addr_t;
  typedef logic [BIT_W-1:0]  boce_bit_t;
  typedef logic [CNT_W-1:0]  boce_cnt_t;
  typedef logic [7:0]        boce_byte_t;

  localparam boce_op_t OP_LOAD_SRC = 2'd0;
  localparam boce_op_t OP_LOAD_DST = 2'd1;
  localparam boce_op_t OP_COPY     = 2'd2;
  localparam boce_op_t OP_READ_DST = 2'd3;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

// File: design/boce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module boce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/boce_merge.sv
// Aligns a two-byte source window and merges it into one destination byte.
module boce_merge import boce_pkg::*; (
  input  boce_byte_t win_hi,
  input  boce_byte_t win_lo,
  input  logic [2:0] offset,
  input  boce_byte_t dst_byte,
  input  boce_addr_t byte_idx,
  input  boce_bit_t  first_bit,
  input  boce_cnt_t  end_bit,
  output boce_byte_t merged
);

  logic [15:0] window;
  boce_byte_t  aligned;
  boce_byte_t  mask;
  boce_cnt_t   bit_addr [8];

  assign window  = {win_hi, win_lo} << offset;
  assign aligned = window[15:8];

  // Bit p counted from the MSB sits at bit address byte_idx*8 + p.
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      bit_addr[p] = {1'b0, byte_idx, 3'(p)};
      mask[7-p]   = (bit_addr[p] >= {1'b0, first_bit}) && (bit_addr[p] < end_bit);
    end
  end

  assign merged = (dst_byte & ~mask) | (aligned & mask);

endmodule

// File: design/bit_offset_copy_engine.sv
// Top level of the bit offset copy engine: command decode, copy sequencer, memories.
//
// The engine holds a source and a destination memory of 256 bytes each and
// takes one item at a time: an item is accepted on a clock edge where start
// is high and busy is low, and busy stays high until its result has been
// shown. Every item yields exactly one result, shown for a single cycle with
// out_valid high; the receiver has no way to hold it, so it must capture the
// result in that cycle. Loads and reads go from accept straight to the result
// state, as does a copy that is empty or out of range. Any other copy passes
// through a prime state and then, for each destination byte it touches, an
// address state that addresses the memories and a merge state that merges the
// aligned source bits into it and writes it back; that read-modify-write of
// the destination memory sets the pace. The high half of the two-byte source
// window is read anew from the source memory for each destination byte, so a
// source byte inside the run is read twice. Bits are numbered from the MSB of
// byte 0; destination bits outside the copied run keep their values. A copy whose source or
// destination run would pass the end of memory is rejected with status 1
// and changes nothing. Memory contents are undefined after reset until the
// host writes them; read_data is zero for every item other than a read.
module bit_offset_copy_engine import boce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  boce_op_t   in_operation,
  input  boce_addr_t in_byte_address,
  input  boce_byte_t in_byte_value,
  input  boce_bit_t  in_source_bit,
  input  boce_bit_t  in_dest_bit,
  input  boce_cnt_t  in_bit_count,
  output logic       out_valid,
  output boce_byte_t out_read_data,
  output logic       out_status
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_MERGE = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Item and copy context, held while the item is in flight.
  boce_op_t          op_r, op_nxt;
  logic              status_r, status_nxt;
  logic              addr_ok_r, addr_ok_nxt;
  boce_addr_t        dbyte_r, dbyte_nxt;
  boce_addr_t        last_r, last_nxt;
  logic [ADDR_W:0]   sbyte_r, sbyte_nxt;
  logic [2:0]        offset_r, offset_nxt;
  boce_bit_t         first_r, first_nxt;
  boce_cnt_t         end_r, end_nxt;
  boce_byte_t        win_hi_r, win_hi_nxt;

  logic              accept;
  logic              addr_ok;
  logic [SUM_W-1:0]  src_sum;
  logic [SUM_W-1:0]  dst_sum;
  logic              range_err;
  logic [CNT_W-1:0]  src_start;
  boce_cnt_t         last_bit;

  logic              src_we;
  boce_addr_t        src_raddr;
  boce_byte_t        src_rdata;
  logic              dst_we;
  boce_addr_t        dst_waddr;
  boce_byte_t        dst_wdata;
  boce_addr_t        dst_raddr;
  boce_byte_t        dst_rdata;
  boce_byte_t        merged;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign addr_ok = ({1'b0, in_byte_address} < (ADDR_W+1)'(MEM_BYTES));

  // Range check on the full sums so that a run ending exactly at the last
  // bit is still legal.
  assign src_sum   = {2'b00, in_source_bit} + {1'b0, in_bit_count};
  assign dst_sum   = {2'b00, in_dest_bit} + {1'b0, in_bit_count};
  assign range_err = (src_sum > BIT_LIMIT) || (dst_sum > BIT_LIMIT);

  // The source byte that feeds the high half of the window for the first
  // destination byte; it may sit one byte before the memory when only its
  // unused low bits would be taken.
  assign src_start = {1'b0, in_source_bit} - {{(CNT_W-3){1'b0}}, in_dest_bit[2:0]};
  assign last_bit  = dst_sum[CNT_W-1:0] - CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    addr_ok_nxt = addr_ok_r;
    dbyte_nxt   = dbyte_r;
    last_nxt    = last_r;
    sbyte_nxt   = sbyte_r;
    offset_nxt  = offset_r;
    first_nxt   = first_r;
    end_nxt     = end_r;
    win_hi_nxt  = win_hi_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt      = in_operation;
          addr_ok_nxt = addr_ok;
          status_nxt  = STATUS_DONE;
          dbyte_nxt   = in_dest_bit[BIT_W-1:3];
          last_nxt    = last_bit[BIT_W-1:3];
          sbyte_nxt   = src_start[CNT_W-1:3];
          offset_nxt  = in_source_bit[2:0] - in_dest_bit[2:0];
          first_nxt   = in_dest_bit;
          end_nxt     = dst_sum[CNT_W-1:0];
          state_nxt   = ST_RESP;
          if (in_operation == OP_COPY) begin
            if (range_err) begin
              status_nxt = STATUS_RANGE;
            end else if (in_bit_count != '0) begin
              state_nxt = ST_PRIME;
            end
          end
        end
      end
      ST_PRIME: begin
        sbyte_nxt = sbyte_r + (ADDR_W+1)'(1);
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        win_hi_nxt = src_rdata;
        state_nxt  = ST_MERGE;
      end
      ST_MERGE: begin
        sbyte_nxt = sbyte_r + (ADDR_W+1)'(1);
        dbyte_nxt = dbyte_r + ADDR_W'(1);
        if (dbyte_r == last_r) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    addr_ok_r <= addr_ok_nxt;
    dbyte_r   <= dbyte_nxt;
    last_r    <= last_nxt;
    sbyte_r   <= sbyte_nxt;
    offset_r  <= offset_nxt;
    first_r   <= first_nxt;
    end_r     <= end_nxt;
    win_hi_r  <= win_hi_nxt;
  end

  // Memory ports. Loads write on the accept edge; a read presents its
  // address on the accept edge so the data is ready in the result cycle.
  assign src_we    = accept && (in_operation == OP_LOAD_SRC) && addr_ok;
  assign src_raddr = sbyte_r[ADDR_W-1:0];

  assign dst_we    = (accept && (in_operation == OP_LOAD_DST) && addr_ok)
                   || (state_r == ST_MERGE);
  assign dst_waddr = (state_r == ST_MERGE) ? dbyte_r : in_byte_address;
  assign dst_wdata = (state_r == ST_MERGE) ? merged : in_byte_value;
  assign dst_raddr = (state_r == ST_IDLE) ? in_byte_address : dbyte_r;

  boce_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (in_byte_address),
    .wdata (in_byte_value),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  boce_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_waddr),
    .wdata (dst_wdata),
    .raddr (dst_raddr),
    .rdata (dst_rdata)
  );

  // In the merge cycle the source port returns the low half of the window
  // and the destination port returns the byte being rewritten.
  boce_merge u_merge (
    .win_hi    (win_hi_r),
    .win_lo    (src_rdata),
    .offset    (offset_r),
    .dst_byte  (dst_rdata),
    .byte_idx  (dbyte_r),
    .first_bit (first_r),
    .end_bit   (end_r),
    .merged    (merged)
  );

  assign out_valid     = (state_r == ST_RESP);
  assign out_read_data = ((op_r == OP_READ_DST) && addr_ok_r) ? dst_rdata : 8'h00;
  assign out_status    = status_r;

endmodule
